/* design/assert_macros.svh */
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

/* design/tjs_pkg.sv */
// types and constants of the top two jet selector
package tjs_pkg;

	localparam int MAX_JETS_DEF = 64;
	localparam int NUM_CELLS = 2;

	localparam int MOM_W = 16;
	localparam int RAP_W = 11;
	localparam int ABS_RAP_W = 10;
	localparam int MASS_W = 16;
	localparam int QUAL_W = 3;
	localparam int OUT_IDX_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic signed [OUT_IDX_W-1:0] IDX_NONE = -7'sd1;

	localparam logic [MOM_W-1:0] MIN_MOMENTUM_RST = 16'd200;
	localparam logic [ABS_RAP_W-1:0] MAX_ABS_RAPIDITY_RST = 10'd250;
	localparam logic [QUAL_W-1:0] QUALITY_MASK_RST = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_MOMENTUM = 2'd0,
		REG_MAX_ABS_RAPIDITY = 2'd1,
		REG_QUALITY_MASK = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [MOM_W-1:0] min_momentum;
		logic [ABS_RAP_W-1:0] max_abs_rapidity;
		logic [QUAL_W-1:0] quality_mask;
	} cfg_t;

	// one kept jet
	typedef struct packed {
		logic valid;
		logic [MOM_W-1:0] mom;
		logic [MASS_W-1:0] mass;
	} entry_t;

	// jet handed from one cell to the next; force marks a displaced entry
	typedef struct packed {
		logic valid;
		logic force_take;
		logic [MOM_W-1:0] mom;
		logic [MASS_W-1:0] mass;
	} cand_t;

endpackage

/* design/tjs_if.sv */
// channel interfaces: jet input, index pair output, register writes
interface tjs_jet_if;
	import tjs_pkg::*;
	logic valid;
	logic ready;
	logic [MOM_W-1:0] jet_momentum;
	logic signed [RAP_W-1:0] jet_rapidity;
	logic [MASS_W-1:0] jet_mass;
	logic [QUAL_W-1:0] jet_quality;
	logic event_last;
	modport source (output valid, jet_momentum, jet_rapidity, jet_mass, jet_quality,
		event_last, input ready);
	modport sink (input valid, jet_momentum, jet_rapidity, jet_mass, jet_quality,
		event_last, output ready);
endinterface

interface tjs_pair_if;
	import tjs_pkg::*;
	logic valid;
	logic ready;
	logic signed [OUT_IDX_W-1:0] heavier_index;
	logic signed [OUT_IDX_W-1:0] lighter_index;
	modport source (output valid, heavier_index, lighter_index, input ready);
	modport sink (input valid, heavier_index, lighter_index, output ready);
endinterface

interface tjs_cfg_if;
	import tjs_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/qualified_top_two_jet_select.sv */
// Top two jet selector. Takes one jet per clock cycle, back to back, and keeps the two
// qualified jets of highest momentum in a row of two insertion cells that compare and
// shift in the same cycle the jet is accepted. In the cycle after the jet flagged last is
// accepted, the index pair sits in the output register (heavier mass first, -1 for none)
// and the cells start the next event empty. A jet is taken every cycle unless a finished
// pair still waits in the output register while the sink is not ready. Jets at position
// MAX_JETS and beyond are ignored, though their last flag still ends the event.
`include "assert_macros.svh"

module qualified_top_two_jet_select import tjs_pkg::*; #(
	parameter int MAX_JETS = MAX_JETS_DEF
) (
	input logic clk,
	input logic arst_n,
	tjs_cfg_if.sink cfg,
	tjs_jet_if.sink jet,
	tjs_pair_if.source pair
);

	localparam int IDX_W = $clog2(MAX_JETS);
	localparam int CNT_W = $clog2(MAX_JETS + 1);

	cfg_t regs;
	logic [CNT_W-1:0] count_q;
	logic accept;
	logic clear;
	logic full;
	logic qualified;
	logic [RAP_W-1:0] abs_rap;

	cand_t chain_c [NUM_CELLS+1];
	logic [IDX_W-1:0] chain_idx [NUM_CELLS+1];
	entry_t upd [NUM_CELLS];
	logic [IDX_W-1:0] upd_idx [NUM_CELLS];

	logic pair_valid_q;
	logic signed [OUT_IDX_W-1:0] heavier_q;
	logic signed [OUT_IDX_W-1:0] lighter_q;
	logic signed [OUT_IDX_W-1:0] lead_field;
	logic signed [OUT_IDX_W-1:0] second_field;
	logic swap;

	tjs_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	assign jet.ready = !pair_valid_q || pair.ready;
	assign accept = jet.valid && jet.ready;
	assign clear = accept && jet.event_last;
	assign full = (count_q == CNT_W'(MAX_JETS));

	// most negative code has magnitude 1024 and never passes the limit
	assign abs_rap = jet.jet_rapidity[RAP_W-1] ? RAP_W'(-jet.jet_rapidity)
		: RAP_W'(jet.jet_rapidity);
	assign qualified = (jet.jet_momentum > regs.min_momentum)
		&& (abs_rap < {1'b0, regs.max_abs_rapidity})
		&& ((jet.jet_quality & regs.quality_mask) == regs.quality_mask);

	assign chain_c[0].valid = accept && !full && qualified;
	assign chain_c[0].force_take = 1'b0;
	assign chain_c[0].mom = jet.jet_momentum;
	assign chain_c[0].mass = jet.jet_mass;
	assign chain_idx[0] = count_q[IDX_W-1:0];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		tjs_cell #(.IDX_W(IDX_W)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(accept),
			.clear(clear),
			.in_c(chain_c[i]),
			.in_idx(chain_idx[i]),
			.out_c(chain_c[i+1]),
			.out_idx(chain_idx[i+1]),
			.upd(upd[i]),
			.upd_idx(upd_idx[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (jet.event_last) begin
				count_q <= '0;
			end else if (!full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// pair is built from the cells' contents including the last jet
	assign lead_field = upd[0].valid ? OUT_IDX_W'(upd_idx[0]) : IDX_NONE;
	assign second_field = upd[1].valid ? OUT_IDX_W'(upd_idx[1]) : IDX_NONE;
	assign swap = upd[0].valid && upd[1].valid && (upd[1].mass > upd[0].mass);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
		end else if (clear) begin
			pair_valid_q <= 1'b1;
		end else if (pair.ready) begin
			pair_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			heavier_q <= swap ? second_field : lead_field;
			lighter_q <= swap ? lead_field : second_field;
		end
	end

	assign pair.valid = pair_valid_q;
	assign pair.heavier_index = heavier_q;
	assign pair.lighter_index = lighter_q;

	`ASSERT_NEXT(a_last_gives_pair, clk, arst_n, clear, pair_valid_q)
	`ASSERT_IMPLIES(a_none_first, clk, arst_n, pair_valid_q && heavier_q == IDX_NONE,
		lighter_q == IDX_NONE)
	`ASSERT_IMPLIES(a_pair_distinct, clk, arst_n, pair_valid_q && heavier_q != IDX_NONE,
		heavier_q != lighter_q)
	`ASSERT_IMPLIES(a_dropped_not_larger, clk, arst_n, chain_c[NUM_CELLS].valid,
		upd[NUM_CELLS-1].valid && chain_c[NUM_CELLS].mom <= upd[NUM_CELLS-1].mom)
	`ASSERT_IMPLIES(a_dropped_not_kept, clk, arst_n, chain_c[NUM_CELLS].valid,
		chain_idx[NUM_CELLS] != upd_idx[NUM_CELLS-1])

endmodule

/* design/tjs_cfg_regs.sv */
// configuration registers of the jet selector
module tjs_cfg_regs import tjs_pkg::*; (
	input logic clk,
	input logic arst_n,
	tjs_cfg_if.sink cfg,
	output cfg_t regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_momentum <= MIN_MOMENTUM_RST;
			regs_q.max_abs_rapidity <= MAX_ABS_RAPIDITY_RST;
			regs_q.quality_mask <= QUALITY_MASK_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MIN_MOMENTUM: regs_q.min_momentum <= cfg.data;
				REG_MAX_ABS_RAPIDITY: regs_q.max_abs_rapidity <= cfg.data[ABS_RAP_W-1:0];
				REG_QUALITY_MASK: regs_q.quality_mask <= cfg.data[QUAL_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* design/tjs_cell.sv */
// one insertion cell: holds a kept jet, passes the smaller one downstream
`include "assert_macros.svh"

module tjs_cell import tjs_pkg::*; #(
	parameter int IDX_W = $clog2(MAX_JETS_DEF)
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic clear,
	input cand_t in_c,
	input logic [IDX_W-1:0] in_idx,
	output cand_t out_c,
	output logic [IDX_W-1:0] out_idx,
	output entry_t upd,
	output logic [IDX_W-1:0] upd_idx
);

	entry_t held_q;
	logic [IDX_W-1:0] idx_q;
	logic take;

	// strict greater keeps the earlier jet on a tie
	assign take = in_c.valid && (!held_q.valid || in_c.force_take || in_c.mom > held_q.mom);

	always_comb begin
		if (take) begin
			upd.valid = 1'b1;
			upd.mom = in_c.mom;
			upd.mass = in_c.mass;
			upd_idx = in_idx;
			out_c.valid = held_q.valid;
			out_c.force_take = held_q.valid;
			out_c.mom = held_q.mom;
			out_c.mass = held_q.mass;
			out_idx = idx_q;
		end else begin
			upd = held_q;
			upd_idx = idx_q;
			out_c = in_c;
			out_c.force_take = 1'b0;
			out_idx = in_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance) begin
			held_q <= clear ? entry_t'('0) : upd;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			idx_q <= upd_idx;
		end
	end

	`ASSERT_IMPLIES(a_force_has_jet, clk, arst_n, in_c.force_take, in_c.valid)
	`ASSERT_IMPLIES(a_pass_not_larger, clk, arst_n, out_c.valid && upd.valid,
		out_c.mom <= upd.mom)
	`ASSERT_NEXT(a_mom_never_drops, clk, arst_n, advance && !clear && held_q.valid,
		held_q.valid && held_q.mom >= $past(held_q.mom))

endmodule

/* tb/jet_pair_checker.sv */
// checker for the top two jet selector: predicts each event's index pair and compares it
module jet_pair_checker import tjs_pkg::*; (
	input logic clk,
	input logic arst_n,
	tjs_cfg_if cfg,
	tjs_jet_if jet,
	tjs_pair_if pair,
	output int fail_count,
	output int pending
);

	localparam int MAX_JETS = MAX_JETS_DEF;

	typedef struct packed {
		logic signed [OUT_IDX_W-1:0] heavier;
		logic signed [OUT_IDX_W-1:0] lighter;
	} index_pair_t;

	index_pair_t pairs_due[$];
	index_pair_t due;

	logic [MOM_W-1:0] min_momentum;
	logic [ABS_RAP_W-1:0] max_abs_rapidity;
	logic [QUAL_W-1:0] quality_mask;

	int jet_pos;
	int lead_idx;
	logic [MOM_W-1:0] lead_mom;
	logic [MASS_W-1:0] lead_mass;
	int second_idx;
	logic [MOM_W-1:0] second_mom;
	logic [MASS_W-1:0] second_mass;

	function automatic void start_event();
		jet_pos = 0;
		lead_idx = -1;
		lead_mom = '0;
		lead_mass = '0;
		second_idx = -1;
		second_mom = '0;
		second_mass = '0;
	endfunction

	// updates the two kept jets and queues the pair when the event closes
	function automatic void absorb_jet(input logic [MOM_W-1:0] mom,
		input logic signed [RAP_W-1:0] rap, input logic [MASS_W-1:0] mass,
		input logic [QUAL_W-1:0] qual, input logic last);
		logic [RAP_W-1:0] abs_rap;
		logic qualified;
		index_pair_t closing;
		// most negative value stays 1024 here, never below the limit
		abs_rap = rap[RAP_W-1] ? ~rap + 1'b1 : rap;
		if (jet_pos < MAX_JETS) begin
			qualified = mom > min_momentum && abs_rap < max_abs_rapidity &&
				(qual & quality_mask) == quality_mask;
			if (qualified) begin
				if (lead_idx < 0 || mom > lead_mom) begin
					second_idx = lead_idx;
					second_mom = lead_mom;
					second_mass = lead_mass;
					lead_idx = jet_pos;
					lead_mom = mom;
					lead_mass = mass;
				end else if (second_idx < 0 || mom > second_mom) begin
					second_idx = jet_pos;
					second_mom = mom;
					second_mass = mass;
				end
			end
			jet_pos++;
		end
		if (last) begin
			if (lead_idx >= 0 && second_idx >= 0 && second_mass > lead_mass) begin
				closing.heavier = OUT_IDX_W'(second_idx);
				closing.lighter = OUT_IDX_W'(lead_idx);
			end else begin
				closing.heavier = OUT_IDX_W'(lead_idx);
				closing.lighter = OUT_IDX_W'(second_idx);
			end
			pairs_due.push_back(closing);
			start_event();
		end
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_momentum = MIN_MOMENTUM_RST;
			max_abs_rapidity = MAX_ABS_RAPIDITY_RST;
			quality_mask = QUALITY_MASK_RST;
			start_event();
			pairs_due.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_MOMENTUM: min_momentum = cfg.data[MOM_W-1:0];
					REG_MAX_ABS_RAPIDITY: max_abs_rapidity = cfg.data[ABS_RAP_W-1:0];
					REG_QUALITY_MASK: quality_mask = cfg.data[QUAL_W-1:0];
					default: ;
				endcase
			end
			if (jet.valid && jet.ready) begin
				absorb_jet(jet.jet_momentum, jet.jet_rapidity, jet.jet_mass, jet.jet_quality,
					jet.event_last);
			end
			if (pair.valid && pair.ready) begin
				if (pairs_due.size() == 0) begin
					$error("index pair with no event closed: heavier_index %0d lighter_index %0d",
						pair.heavier_index, pair.lighter_index);
					fail_count++;
				end else begin
					due = pairs_due.pop_front();
					if (pair.heavier_index !== due.heavier) begin
						$error("heavier_index expected %0d actual %0d", due.heavier,
							pair.heavier_index);
						fail_count++;
					end
					if (pair.lighter_index !== due.lighter) begin
						$error("lighter_index expected %0d actual %0d", due.lighter,
							pair.lighter_index);
						fail_count++;
					end
				end
			end
			pending = pairs_due.size();
		end
	end

endmodule

/* tb/qualified_top_two_jet_select_tb.sv */
// testbench top for the top two jet selector: reset, stimulus, register settings, verdict
module qualified_top_two_jet_select_tb;
	import tjs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int cycle_count = 0;
	int jets_sent = 0;
	int events_sent = 0;
	int settings_used = 1;
	logic tx_calm = 1'b0;

	// stimulus shaping only, the checker keeps its own copy
	logic [MOM_W-1:0] cur_min = MIN_MOMENTUM_RST;
	int cur_rap = MAX_ABS_RAPIDITY_RST;
	logic [QUAL_W-1:0] cur_mask = QUALITY_MASK_RST;

	tjs_cfg_if cfg_ch();
	tjs_jet_if jet_ch();
	tjs_pair_if pair_ch();

	qualified_top_two_jet_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.jet(jet_ch),
		.pair(pair_ch)
	);

	jet_pair_checker pair_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.jet(jet_ch),
		.pair(pair_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_jet(input logic [MOM_W-1:0] mom, input int rap,
		input logic [MASS_W-1:0] mass, input logic [QUAL_W-1:0] qual, input logic last);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			jet_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		jet_ch.valid <= 1'b1;
		jet_ch.jet_momentum <= mom;
		jet_ch.jet_rapidity <= RAP_W'(rap);
		jet_ch.jet_mass <= mass;
		jet_ch.jet_quality <= qual;
		jet_ch.event_last <= last;
		do @(posedge clk); while (!(jet_ch.valid && jet_ch.ready));
		jets_sent++;
		if (last)
			events_sent++;
	endtask

	// block idle: no pair outstanding, plus the output register latency
	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [MOM_W-1:0] min_mom,
		input logic [ABS_RAP_W-1:0] rap_lim, input logic [QUAL_W-1:0] mask);
		wait_idle();
		// upper data bits beyond each register width carry noise
		write_reg(REG_MIN_MOMENTUM, min_mom);
		write_reg(REG_MAX_ABS_RAPIDITY, CFG_DATA_W'({$urandom(), rap_lim}));
		write_reg(REG_QUALITY_MASK, CFG_DATA_W'({$urandom(), mask}));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
		cur_min = min_mom;
		cur_rap = rap_lim;
		cur_mask = mask;
		settings_used++;
	endtask

	task automatic send_event(input int len);
		logic [MOM_W-1:0] mom_pool [4];
		logic [MASS_W-1:0] mass_pool [2];
		logic [MOM_W-1:0] mom;
		logic [MASS_W-1:0] mass;
		logic [QUAL_W-1:0] qual;
		int rap;
		tx_calm = ($urandom_range(0, 3) == 0);
		// small pools near the threshold give momentum ties and equal masses
		foreach (mom_pool[k])
			mom_pool[k] = cur_min + MOM_W'($urandom_range(0, 40)) - MOM_W'(10);
		foreach (mass_pool[k])
			mass_pool[k] = MASS_W'($urandom());
		for (int n = 0; n < len; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: mom = mom_pool[$urandom_range(0, 3)];
				3: mom = cur_min - MOM_W'(1);
				4: mom = cur_min;
				5: mom = cur_min + MOM_W'(1);
				default: mom = MOM_W'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: rap = int'($urandom_range(0, 2000)) - 1000;
				6: rap = $urandom_range(0, 1) ? cur_rap - 1 : 1 - cur_rap;
				7: rap = $urandom_range(0, 1) ? cur_rap : -cur_rap;
				8: rap = -1024;
				default: rap = int'($urandom_range(0, 2047)) - 1024;
			endcase
			qual = $urandom_range(0, 1) ? (cur_mask | QUAL_W'($urandom())) : QUAL_W'($urandom());
			mass = ($urandom_range(0, 2) == 0) ? mass_pool[$urandom_range(0, 1)] :
				MASS_W'($urandom());
			send_jet(mom, rap, mass, qual, n == len - 1);
		end
	endtask

	task automatic run_phase(input int quota, input logic force_long);
		int count;
		int len;
		count = 0;
		while (count < quota) begin
			if (force_long) begin
				// runs past the position limit
				len = $urandom_range(66, 72);
				force_long = 1'b0;
			end else if ($urandom_range(0, 14) == 0) begin
				len = $urandom_range(60, 72);
			end else begin
				len = $urandom_range(1, 8);
			end
			send_event(len);
			count += (len > MAX_JETS_DEF) ? MAX_JETS_DEF : len;
		end
		jet_ch.valid <= 1'b0;
	endtask

	initial begin : rx_side
		int stall;
		int calm_left;
		pair_ch.ready = 1'b0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = $urandom_range(0, 15);
				if ($urandom_range(0, 5) == 0)
					calm_left = $urandom_range(4, 16);
			end
			if (stall > 0) begin
				pair_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pair_ch.ready <= 1'b1;
			do @(posedge clk); while (!(pair_ch.valid && pair_ch.ready));
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		jet_ch.valid = 1'b0;
		jet_ch.jet_momentum = '0;
		jet_ch.jet_rapidity = '0;
		jet_ch.jet_mass = '0;
		jet_ch.jet_quality = '0;
		jet_ch.event_last = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events under reset settings
		send_jet(16'd201, 0, 16'd10, 3'd2, 1'b1);
		send_jet(16'd200, 0, 16'd10, 3'd2, 1'b1);
		// rapidity just inside and at the limit, most negative value, top momentum
		send_jet(16'd300, -249, 16'd5, 3'd2, 1'b0);
		send_jet(16'd300, 250, 16'd5, 3'd2, 1'b0);
		send_jet(16'd400, -1024, 16'd5, 3'd7, 1'b0);
		send_jet(16'd500, -250, 16'd5, 3'd7, 1'b0);
		send_jet(16'hFFFF, 249, 16'd0, 3'd7, 1'b1);
		// quality mask miss, then momentum ties with equal masses
		send_jet(16'd500, 0, 16'd100, 3'd5, 1'b0);
		send_jet(16'd500, 0, 16'd100, 3'd2, 1'b0);
		send_jet(16'd500, 0, 16'd100, 3'd3, 1'b0);
		send_jet(16'd500, 0, 16'd100, 3'd7, 1'b1);
		// mass extremes swap the order
		send_jet(16'd1000, 0, 16'hFFFF, 3'd2, 1'b0);
		send_jet(16'd2000, 0, 16'd0, 3'd2, 1'b1);
		// lead displaced to second, third jet displaces second
		send_jet(16'd300, 10, 16'd40, 3'd6, 1'b0);
		send_jet(16'd400, -10, 16'd30, 3'd2, 1'b0);
		send_jet(16'd350, 100, 16'd20, 3'd3, 1'b0);
		send_jet(16'd100, 0, 16'd90, 3'd2, 1'b1);
		jet_ch.valid <= 1'b0;

		apply_setting(MOM_W'($urandom_range(0, 3000)), ABS_RAP_W'($urandom_range(50, 1000)),
			QUAL_W'($urandom()));
		run_phase(75, 1'b1);
		apply_setting(16'd0, 10'd1000, 3'd0);
		run_phase(75, 1'b0);
		apply_setting(16'hFFFF, 10'd0, 3'd7);
		run_phase(75, 1'b0);
		apply_setting(MOM_W'($urandom_range(0, 3000)), ABS_RAP_W'($urandom_range(50, 1000)),
			QUAL_W'($urandom()));
		run_phase(75, 1'b0);
		apply_setting(16'd0, 10'd1000, 3'd7);
		run_phase(75, 1'b0);
		apply_setting(MOM_W'($urandom_range(0, 3000)), ABS_RAP_W'($urandom_range(50, 1000)),
			QUAL_W'($urandom()));
		run_phase(75, 1'b0);
		wait_idle();

		$display("sent %0d jets in %0d events under %0d register settings", jets_sent,
			events_sent, settings_used);
		$display("covered thresholds, momentum ties, equal masses and events past the jet limit");
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/tjs_pkg.sv
design/tjs_if.sv
design/tjs_cfg_regs.sv
design/tjs_cell.sv
design/qualified_top_two_jet_select.sv
tb/jet_pair_checker.sv
tb/qualified_top_two_jet_select_tb.sv
